>>> sv/assert_macros.svh
// Assertion macros used by the RTL of the byte budget LRU cache.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant violated");
`define ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sequence check violated");
`else
`define ASSERT_ALWAYS(label, cond)
`define ASSERT_NEXT(label, pre, post)
`endif
`endif

>>> sv/bblru_pkg.sv
// Shared types and constants of the byte budget LRU cache.
package bblru_pkg;
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam int SIZE_BITS = 27;
    localparam int DIM_BITS = 13;
    localparam int HANDLE_BITS = 32;
    localparam int TOTAL_BITS = 32;
    localparam int OUT_CNT_BITS = 5;
    localparam logic [30:0] LIMIT_RESET = 31'd67108864;
    localparam logic [SIZE_BITS-1:0] SIZE_MAX = {SIZE_BITS{1'b1}};
    typedef logic [SIZE_BITS-1:0] size_t;
endpackage

>>> sv/bblru_ram.sv
// Generic single write port RAM with a registered read port.
module bblru_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> sv/byte_budget_lru_cache.sv
// Top level of the byte budget LRU cache: sequencer, recency list and entry stores.
// One request is handled at a time; the input stays closed while a request is in progress
// and while a response is held, and the key search reads and compares one slot after another.
// Reset: valid bits, count, byte total and control clear at once; byte_limit returns to 64 MiB.
`include "assert_macros.svh"
module byte_budget_lru_cache #(
    parameter int ENTRIES = 16,
    parameter int KEY_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [31:0] key,
    input  logic [31:0] value_handle,
    input  logic [12:0] pix_width,
    input  logic [12:0] pix_height,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        hit,
    output logic [31:0] found_handle,
    output logic [4:0]  evicted_count,
    output logic [30:0] bytes_in_use,
    output logic [4:0]  entries_in_use,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int SW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_SADDR = 4'd2;
    localparam logic [3:0] S_SCMP  = 4'd3;
    localparam logic [3:0] S_HREAD = 4'd4;
    localparam logic [3:0] S_HDONE = 4'd5;
    localparam logic [3:0] S_RADDR = 4'd6;
    localparam logic [3:0] S_RSUB  = 4'd7;
    localparam logic [3:0] S_EADDR = 4'd8;
    localparam logic [3:0] S_ESUB  = 4'd9;
    localparam logic [3:0] S_WRITE = 4'd10;
    localparam logic [3:0] S_CHK   = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;

    logic [3:0]            state_reg, state_next;
    logic [1:0]            op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [31:0]           handle_reg;
    logic [12:0]           w_reg, h_reg;
    bblru_pkg::size_t      size_reg, size_next;
    logic [SW:0]           idx_reg, idx_next;
    logic [SW-1:0]         slot_reg, slot_next;
    logic                  hit_reg, hit_next;
    logic                  post_reg, post_next;
    logic [CW:0]           evict_reg, evict_next;
    logic [31:0]           found_reg, found_next;
    logic [31:0]           total_reg, total_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [ENTRIES-1:0]    valid_reg, valid_next;
    logic [SW-1:0]         order_reg [ENTRIES];
    logic [SW-1:0]         order_next [ENTRIES];
    logic [30:0]           limit_reg;

    logic                  accept;
    logic [63:0]           key_wide;
    logic [KEY_BITS-1:0]   key_in;
    logic [27:0]           product;
    logic [SW-1:0]         mem_addr;
    logic [KEY_BITS-1:0]   key_rd;
    logic [31:0]           handle_rd;
    bblru_pkg::size_t      size_rd;
    logic [SW-1:0]         free_slot;
    logic [SW-1:0]         hit_pos;
    logic [SW-1:0]         drop_pos;
    logic                  do_drop;
    logic                  do_append;
    logic [SW-1:0]         append_slot;
    logic [CW-1:0]         append_pos;
    logic [31:0]           total_sub;
    logic                  ram_we;
    logic [31:0]           cnt_wide, ev_wide;

    assign accept = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {1'b0, limit_reg} : 32'd0;

    // The key is taken modulo 2^KEY_BITS.
    assign key_wide = {32'd0, key};
    assign key_in = key_wide[KEY_BITS-1:0];

    // Weight in bytes: four bytes per pixel.
    assign product = {26'(w_reg) * 26'(h_reg), 2'b00};

    // First free slot, lowest index first.
    always_comb
    begin
        free_slot = '0;
        for (int s = ENTRIES - 1; s >= 0; s--)
        begin
            if (!valid_reg[s])
            begin
                free_slot = SW'(s);
            end
        end
    end

    // Recency position of the matched slot.
    always_comb
    begin
        hit_pos = '0;
        for (int p = ENTRIES - 1; p >= 0; p--)
        begin
            if (order_reg[p] == slot_reg && p < int'(count_reg))
            begin
                hit_pos = SW'(p);
            end
        end
    end

    // One read address is shared by the three entry stores.
    always_comb
    begin
        case (state_reg)
            S_SADDR: mem_addr = idx_reg[SW-1:0];
            S_HREAD: mem_addr = slot_reg;
            S_RADDR: mem_addr = slot_reg;
            S_EADDR: mem_addr = order_reg[0];
            default: mem_addr = '0;
        endcase
    end

    assign ram_we = (state_reg == S_WRITE);

    bblru_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
        .clk(clk), .we(ram_we), .waddr(free_slot), .wdata(key_reg),
        .raddr(mem_addr), .rdata(key_rd)
    );

    bblru_ram #(.WIDTH(bblru_pkg::HANDLE_BITS), .DEPTH(ENTRIES)) u_handle_ram (
        .clk(clk), .we(ram_we), .waddr(free_slot), .wdata(handle_reg),
        .raddr(mem_addr), .rdata(handle_rd)
    );

    bblru_ram #(.WIDTH(bblru_pkg::SIZE_BITS), .DEPTH(ENTRIES)) u_size_ram (
        .clk(clk), .we(ram_we), .waddr(free_slot), .wdata(size_reg),
        .raddr(mem_addr), .rdata(size_rd)
    );

    // Byte total less the size just read, floored at zero.
    assign total_sub = (total_reg >= 32'(size_rd)) ? total_reg - 32'(size_rd) : 32'd0;

    // Main sequencer.
    always_comb
    begin
        state_next = state_reg;
        size_next = size_reg;
        idx_next = idx_reg;
        slot_next = slot_reg;
        hit_next = hit_reg;
        post_next = post_reg;
        evict_next = evict_reg;
        found_next = found_reg;
        total_next = total_reg;
        count_next = count_reg;
        valid_next = valid_reg;
        do_drop = 1'b0;
        drop_pos = '0;
        do_append = 1'b0;
        append_slot = '0;
        append_pos = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    hit_next = 1'b0;
                    found_next = 32'd0;
                    evict_next = '0;
                    post_next = 1'b0;
                    idx_next = '0;
                    state_next = S_FIN;
                    if (opcode == bblru_pkg::OP_CLEAR)
                    begin
                        valid_next = '0;
                        count_next = '0;
                        total_next = 32'd0;
                    end
                    else if (opcode == bblru_pkg::OP_LOOKUP && key_in != '0)
                    begin
                        state_next = S_SADDR;
                    end
                    else if (opcode == bblru_pkg::OP_INSERT && key_in != '0 &&
                             pix_width != 13'd0 && pix_height != 13'd0)
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                size_next = product[27] ? bblru_pkg::SIZE_MAX : product[26:0];
                state_next = S_SADDR;
            end
            S_SADDR:
            begin
                if (idx_reg == (SW + 1)'(ENTRIES))
                begin
                    if (op_reg == bblru_pkg::OP_LOOKUP)
                    begin
                        state_next = S_FIN;
                    end
                    else if (count_reg == CW'(ENTRIES))
                    begin
                        state_next = S_EADDR;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
                else
                begin
                    state_next = S_SCMP;
                end
            end
            S_SCMP:
            begin
                if (valid_reg[idx_reg[SW-1:0]] && key_rd == key_reg)
                begin
                    slot_next = idx_reg[SW-1:0];
                    state_next = (op_reg == bblru_pkg::OP_LOOKUP) ? S_HREAD : S_RADDR;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_SADDR;
                end
            end
            S_HREAD:
            begin
                state_next = S_HDONE;
            end
            S_HDONE:
            begin
                hit_next = 1'b1;
                found_next = handle_rd;
                do_drop = 1'b1;
                drop_pos = hit_pos;
                do_append = 1'b1;
                append_slot = slot_reg;
                append_pos = count_reg - 1'b1;
                state_next = S_FIN;
            end
            S_RADDR:
            begin
                state_next = S_RSUB;
            end
            S_RSUB:
            begin
                total_next = total_sub;
                valid_next[slot_reg] = 1'b0;
                do_drop = 1'b1;
                drop_pos = hit_pos;
                count_next = count_reg - 1'b1;
                state_next = S_WRITE;
            end
            S_EADDR:
            begin
                state_next = S_ESUB;
            end
            S_ESUB:
            begin
                total_next = total_sub;
                valid_next[order_reg[0]] = 1'b0;
                do_drop = 1'b1;
                drop_pos = '0;
                count_next = count_reg - 1'b1;
                evict_next = evict_reg + 1'b1;
                state_next = post_reg ? S_CHK : S_WRITE;
            end
            S_WRITE:
            begin
                valid_next[free_slot] = 1'b1;
                do_append = 1'b1;
                append_slot = free_slot;
                append_pos = count_reg;
                count_next = count_reg + 1'b1;
                total_next = total_reg + 32'(size_reg);
                post_next = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (total_reg > 32'(limit_reg) && count_reg != '0)
                begin
                    state_next = S_EADDR;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Recency list update: every position moves independently.
    always_comb
    begin
        for (int p = 0; p < ENTRIES; p++)
        begin
            order_next[p] = order_reg[p];
            if (do_drop && p >= int'(drop_pos) && p + 1 < ENTRIES)
            begin
                order_next[p] = order_reg[p + 1];
            end
            if (do_append && p == int'(append_pos))
            begin
                order_next[p] = append_slot;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            total_reg <= 32'd0;
            valid_reg <= '0;
            limit_reg <= bblru_pkg::LIMIT_RESET;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
            valid_reg <= valid_next;
            if (psel && penable && pwrite && pready && paddr == 2'd0)
            begin
                limit_reg <= pwdata[30:0];
            end
            if (state_reg == S_FIN && (!out_valid || out_ready))
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    assign cnt_wide = 32'(count_reg);
    assign ev_wide = 32'(evict_reg);

    // Payload registers.
    always_ff @(posedge clk)
    begin
        size_reg <= size_next;
        idx_reg <= idx_next;
        slot_reg <= slot_next;
        hit_reg <= hit_next;
        post_reg <= post_next;
        evict_reg <= evict_next;
        found_reg <= found_next;
        for (int p = 0; p < ENTRIES; p++)
        begin
            order_reg[p] <= order_next[p];
        end
        if (accept)
        begin
            op_reg <= opcode;
            key_reg <= key_in;
            handle_reg <= value_handle;
            w_reg <= pix_width;
            h_reg <= pix_height;
        end
        if (state_reg == S_FIN && (!out_valid || out_ready))
        begin
            hit <= hit_reg;
            found_handle <= found_reg;
            evicted_count <= (ev_wide > 32'd31) ? 5'd31 : ev_wide[4:0];
            bytes_in_use <= (total_reg > 32'h7FFFFFFF) ? 31'h7FFFFFFF : total_reg[30:0];
            entries_in_use <= (cnt_wide > 32'd31) ? 5'd31 : cnt_wide[4:0];
        end
    end

    `ASSERT_ALWAYS(a_count_bound, int'(count_reg) <= ENTRIES)
    `ASSERT_ALWAYS(a_valid_matches_count,
        (state_reg != S_IDLE) || ($countones(valid_reg) == int'(count_reg)))
    `ASSERT_NEXT(a_evict_decrements, state_reg == S_ESUB, $past(count_reg) == count_reg + CW'(1))
    `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, state_reg != S_IDLE)
endmodule

>>> bench/tb.sv
// Self-checking bench for the byte budget LRU cache: directed and random requests checked against a predictor.
`timescale 1ns / 1ps
module tb;
    localparam int SLOTS = 16;
    localparam int CYCLE_LIMIT = 900000;
    localparam logic [1:0] OP_NOP = 2'd3;
    localparam logic [1:0] REG_BYTE_LIMIT = 2'd0;

    // A request as the driver presents it.
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] key;
        logic [31:0] handle;
        logic [12:0] w;
        logic [12:0] h;
    } cache_req_t;

    // The response fields that the block reports for every request.
    typedef struct packed {
        logic        hit;
        logic [31:0] handle;
        logic [4:0]  evicted;
        logic [30:0] bytes;
        logic [4:0]  entries;
    } cache_rsp_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [31:0] key;
    logic [31:0] value_handle;
    logic [12:0] pix_width;
    logic [12:0] pix_height;
    logic        out_valid;
    logic        out_ready;
    logic        hit;
    logic [31:0] found_handle;
    logic [4:0]  evicted_count;
    logic [30:0] bytes_in_use;
    logic [4:0]  entries_in_use;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    byte_budget_lru_cache dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .key(key), .value_handle(value_handle),
        .pix_width(pix_width), .pix_height(pix_height),
        .out_valid(out_valid), .out_ready(out_ready),
        .hit(hit), .found_handle(found_handle), .evicted_count(evicted_count),
        .bytes_in_use(bytes_in_use), .entries_in_use(entries_in_use),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Predictor state: a shadow copy of the cache table and its recency list.
    logic [31:0]                     shadow_key [SLOTS];
    logic [31:0]                     shadow_handle [SLOTS];
    logic [bblru_pkg::SIZE_BITS-1:0] shadow_size [SLOTS];
    logic                            shadow_valid [SLOTS];
    int                              lru_list [SLOTS];   // slot numbers, oldest first
    int                              live_count;
    longint                          byte_total;
    logic [30:0]                     budget;

    cache_req_t pending_reqs[$];
    cache_rsp_t expected_rsps[$];
    int  fail_count;
    int  rsp_count;
    int  req_total;
    int  hit_count;
    int  evict_count;
    longint cycle_count;
    int  hold_off;         // a long stall of the response side, counted down by the monitor

    // Remove position pos from the recency list, shifting younger slots down.
    function automatic void unlink_pos(int pos);
        for (int p = pos; p + 1 < live_count; p++)
            lru_list[p] = lru_list[p + 1];
        live_count--;
    endfunction

    function automatic void evict_lru();
        int s;
        s = lru_list[0];
        byte_total = (byte_total >= shadow_size[s]) ? byte_total - shadow_size[s] : 0;
        shadow_valid[s] = 1'b0;
        unlink_pos(0);
    endfunction

    function automatic int find_key(logic [31:0] k);
        for (int p = 0; p < live_count; p++)
            if (shadow_valid[lru_list[p]] && shadow_key[lru_list[p]] == k)
                return p;
        return -1;
    endfunction

    // Work out the response of one request and advance the shadow table.
    function automatic cache_rsp_t predict_cache(cache_req_t r);
        cache_rsp_t rsp;
        int p;
        int s;
        longint weight;
        rsp = '0;
        if (r.op == bblru_pkg::OP_LOOKUP) begin
            if (r.key != 0) begin
                p = find_key(r.key);
                if (p >= 0) begin
                    s = lru_list[p];
                    unlink_pos(p);
                    lru_list[live_count] = s;
                    live_count++;
                    rsp.hit = 1'b1;
                    rsp.handle = shadow_handle[s];
                end
            end
        end else if (r.op == bblru_pkg::OP_INSERT) begin
            if (r.key != 0 && r.w != 0 && r.h != 0) begin
                weight = longint'(r.w) * longint'(r.h) * 4;
                if (weight > bblru_pkg::SIZE_MAX)
                    weight = bblru_pkg::SIZE_MAX;
                p = find_key(r.key);
                if (p >= 0) begin
                    s = lru_list[p];
                    byte_total = (byte_total >= shadow_size[s]) ? byte_total - shadow_size[s] : 0;
                    shadow_valid[s] = 1'b0;
                    unlink_pos(p);
                end else if (live_count >= SLOTS) begin
                    evict_lru();
                    rsp.evicted++;
                end
                s = 0;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!shadow_valid[i])
                        s = i;
                shadow_key[s] = r.key;
                shadow_handle[s] = r.handle;
                shadow_size[s] = weight[bblru_pkg::SIZE_BITS-1:0];
                shadow_valid[s] = 1'b1;
                lru_list[live_count] = s;
                live_count++;
                byte_total += weight;
                while (byte_total > budget && live_count > 0) begin
                    evict_lru();
                    rsp.evicted++;
                end
            end
        end else if (r.op == bblru_pkg::OP_CLEAR) begin
            for (int i = 0; i < SLOTS; i++)
                shadow_valid[i] = 1'b0;
            live_count = 0;
            byte_total = 0;
        end
        rsp.bytes = (byte_total > 64'h7FFFFFFF) ? 31'h7FFFFFFF : byte_total[30:0];
        rsp.entries = live_count[4:0];
        return rsp;
    endfunction

    // Driver: one request from the queue at a time, with a random gap after each.
    int send_gap;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else if (in_valid && !in_ready) begin
            // Hold the request steady until the block takes it.
        end else begin
            if (in_valid)
                expected_rsps.push_back(predict_cache({opcode, key, value_handle,
                                                       pix_width, pix_height}));
            if (send_gap > 0 || pending_reqs.size() == 0) begin
                in_valid <= 1'b0;
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
            end else begin
                cache_req_t r;
                r = pending_reqs.pop_front();
                in_valid <= 1'b1;
                opcode <= r.op;
                key <= r.key;
                value_handle <= r.handle;
                pix_width <= r.w;
                pix_height <= r.h;
                send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            end
        end
    end

    // Monitor: checks each accepted response against the oldest prediction.
    int recv_gap;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (out_valid && out_ready) begin
                cache_rsp_t want;
                rsp_count++;
                if (expected_rsps.size() == 0) begin
                    $error("response with no request outstanding");
                    fail_count++;
                end else begin
                    want = expected_rsps.pop_front();
                    if (hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, hit);
                        fail_count++;
                    end
                    if (found_handle !== want.handle) begin
                        $error("found_handle: expected %h, got %h", want.handle, found_handle);
                        fail_count++;
                    end
                    if (evicted_count !== want.evicted) begin
                        $error("evicted_count: expected %0d, got %0d",
                               want.evicted, evicted_count);
                        fail_count++;
                    end
                    if (bytes_in_use !== want.bytes) begin
                        $error("bytes_in_use: expected %0d, got %0d", want.bytes, bytes_in_use);
                        fail_count++;
                    end
                    if (entries_in_use !== want.entries) begin
                        $error("entries_in_use: expected %0d, got %0d",
                               want.entries, entries_in_use);
                        fail_count++;
                    end
                    if (want.hit)
                        hit_count++;
                    evict_count += want.evicted;
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                out_ready <= 1'b0;
            end else if (out_valid && out_ready) begin
                // Draw the wait before the next response.
                recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Cycle counter that bounds the run.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Register writes go through a setup phase and then an access phase.
    task automatic write_reg(logic [1:0] addr, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Set the budget while idle and mirror it in the predictor.
    task automatic set_budget(logic [30:0] limit);
        write_reg(REG_BYTE_LIMIT, {1'b0, limit});
        budget = limit;
    endtask

    // Queue one request and count it, so that the bench knows how many responses to await.
    function automatic void queue_req(cache_req_t r);
        pending_reqs.push_back(r);
        req_total++;
    endfunction

    // Wait until every queued request has been answered and checked; the block is then
    // back at rest, since it returns to idle once it has put out its response.
    task automatic drain();
        while (rsp_count < req_total)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic cache_req_t make_req(logic [1:0] op, logic [31:0] k, logic [31:0] hd,
                                            logic [12:0] w, logic [12:0] h);
        cache_req_t r;
        r.op = op;
        r.key = k;
        r.handle = hd;
        r.w = w;
        r.h = h;
        return r;
    endfunction

    // Random request drawn mostly from a small key pool so that hits and
    // replacements are frequent; sizes are mostly small, some span the full field range.
    function automatic cache_req_t random_req(int pool);
        cache_req_t r;
        int pick;
        pick = $urandom_range(0, 99);
        r.handle = $urandom();
        r.key = ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(1, pool));
        if ($urandom_range(0, 40) == 0)
            r.key = 0;
        if ($urandom_range(0, 3) == 0) begin
            r.w = 13'($urandom_range(0, 8191));
            r.h = 13'($urandom_range(0, 8191));
        end else begin
            r.w = 13'($urandom_range(1, 64));
            r.h = 13'($urandom_range(1, 64));
        end
        if ($urandom_range(0, 30) == 0)
            r.w = 0;
        if (pick < 45)
            r.op = bblru_pkg::OP_LOOKUP;
        else if (pick < 92)
            r.op = bblru_pkg::OP_INSERT;
        else if (pick < 96)
            r.op = bblru_pkg::OP_CLEAR;
        else
            r.op = OP_NOP;
        return r;
    endfunction

    initial begin
        logic [30:0] budgets [5];
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        opcode = OP_NOP;
        key = '0;
        value_handle = '0;
        pix_width = '0;
        pix_height = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fail_count = 0;
        rsp_count = 0;
        req_total = 0;
        hit_count = 0;
        evict_count = 0;
        cycle_count = 0;
        hold_off = 0;
        budget = bblru_pkg::LIMIT_RESET;
        live_count = 0;
        byte_total = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_key[i] = '0;
            shadow_handle[i] = '0;
            shadow_size[i] = '0;
            lru_list[i] = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part at the reset budget: the special cases and field extremes.
        queue_req(make_req(bblru_pkg::OP_LOOKUP, 32'd0, 32'hFFFFFFFF, 13'd1, 13'd1));
        queue_req(make_req(bblru_pkg::OP_INSERT, 32'd0, 32'h1, 13'd5, 13'd5));
        queue_req(make_req(bblru_pkg::OP_INSERT, 32'd7, 32'h2, 13'd0, 13'd5));
        queue_req(make_req(bblru_pkg::OP_INSERT, 32'd7, 32'h3, 13'd5, 13'd0));
        queue_req(make_req(bblru_pkg::OP_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF,
                           13'd4096, 13'd4096));
        queue_req(make_req(bblru_pkg::OP_LOOKUP, 32'hFFFFFFFF, 32'h0, 13'd0, 13'd0));
        queue_req(make_req(bblru_pkg::OP_INSERT, 32'hFFFFFFFF, 32'hA5A5A5A5, 13'd1, 13'd1));
        // An oversized image saturates its weight and evicts itself at once.
        queue_req(make_req(bblru_pkg::OP_INSERT, 32'h55, 32'h5, 13'h1FFF, 13'h1FFF));
        queue_req(make_req(bblru_pkg::OP_LOOKUP, 32'h55, 32'h0, 13'd0, 13'd0));
        // Fill past sixteen keys so that the table evicts its oldest entry.
        for (int i = 1; i <= 17; i++)
            queue_req(make_req(bblru_pkg::OP_INSERT, 32'(i), 32'(i * 3), 13'd2, 13'd3));
        queue_req(make_req(bblru_pkg::OP_LOOKUP, 32'd2, 32'h0, 13'd0, 13'd0));
        queue_req(make_req(OP_NOP, 32'd9, 32'h9, 13'd9, 13'd9));
        queue_req(make_req(bblru_pkg::OP_CLEAR, 32'd0, 32'h0, 13'd0, 13'd0));
        drain();

        // Random phases, each at its own budget, including zero and the maximum.
        budgets[0] = 31'd0;
        budgets[1] = 31'd40000;
        budgets[2] = 31'd1073741824;
        budgets[3] = 31'h7FFFFFFF;
        budgets[4] = 31'd200000;
        for (int ph = 0; ph < 5; ph++) begin
            set_budget(budgets[ph]);
            for (int n = 0; n < 180; n++)
                queue_req(random_req(ph == 1 ? 12 : 24));
            if (ph == 2) begin
                // Stall the response side while requests keep coming in.
                hold_off = 400;
            end
            drain();
            // The sender pauses here until every response has arrived.
        end

        $display("tb: %0d responses checked, %0d lookup hits, %0d evictions, 6 budgets",
                 rsp_count, hit_count, evict_count);
        if (fail_count == 0 && expected_rsps.size() == 0 && rsp_count == req_total)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
